FILE: rtl/lspcd_pkg.sv
// shared types and constants for the pilot complex divide block
`timescale 1ns / 1ps
`default_nettype none

package lspcd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_WIDTH        = 32;
  localparam logic [CFG_WIDTH-1:0] MIN_POWER_RESET = CFG_WIDTH'(100);
  localparam int FIFO_DEPTH       = 4;

  // per-item classification carried from the front end to the divider
  typedef struct packed {
    logic too_small;
    logic neg_re;
    logic neg_im;
  } lspcd_flags_t;

endpackage

`default_nettype wire

FILE: rtl/lspcd_fifo.sv
// short register queue between the classifier and the divider pipeline
`timescale 1ns / 1ps
`default_nettype none

module lspcd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = lspcd_pkg::FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      pop_data_o,
  output logic                   valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full_o     = (count_r == CNT_W'(DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_data_o = mem_r[rd_ptr_r];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lspcd_front.sv
// front end: products, reference power, threshold check and numerator magnitudes
`timescale 1ns / 1ps
`default_nettype none

module lspcd_front #(
  parameter int SAMPLE_WIDTH = lspcd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lspcd_pkg::CFG_WIDTH-1:0] cfg_wr_data,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rx_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rx_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] ref_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] ref_im_i,
  output logic                                push_o,
  input  wire logic                           full_i,
  output lspcd_pkg::lspcd_flags_t             flags_o,
  output logic [2*SAMPLE_WIDTH-1:0]           mag_re_o,
  output logic [2*SAMPLE_WIDTH-1:0]           mag_im_o,
  output logic [SAMPLE_WIDTH:0]               div_o
);

  import lspcd_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = 2 * SW;
  localparam int NW  = 2 * SW + 1;
  localparam int CW  = (PW > CFG_WIDTH) ? PW : CFG_WIDTH;

  logic [CFG_WIDTH-1:0] min_power_r;
  logic                 f_en;
  logic                 va_r, vb_r;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_xr_r, p_xi_r;

  logic signed [NW-1:0] num_re, num_im;
  logic [PW-1:0]        power;
  logic [SW:0]          div_nxt;
  lspcd_flags_t         flags_nxt;
  logic [PW-1:0]        mag_re_nxt, mag_im_nxt;
  logic [NW-1:0]        abs_re, abs_im;

  lspcd_flags_t         flags_r;
  logic [PW-1:0]        mag_re_r, mag_im_r;
  logic [SW:0]          div_r;

  // whole front end stalls only when its last stage holds and the queue is full
  assign f_en       = !vb_r || !full_i;
  assign in_ready_o = f_en;
  assign push_o     = vb_r && !full_i;
  assign flags_o    = flags_r;
  assign mag_re_o   = mag_re_r;
  assign mag_im_o   = mag_im_r;
  assign div_o      = div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_power_r <= MIN_POWER_RESET;
    end else if (cfg_wr_en) begin
      min_power_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (f_en) begin
      va_r <= in_valid_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      p_rr_r <= PW'(rx_re_i) * PW'(ref_re_i);
      p_ii_r <= PW'(rx_im_i) * PW'(ref_im_i);
      p_ir_r <= PW'(rx_im_i) * PW'(ref_re_i);
      p_ri_r <= PW'(rx_re_i) * PW'(ref_im_i);
      p_xr_r <= PW'(ref_re_i) * PW'(ref_re_i);
      p_xi_r <= PW'(ref_im_i) * PW'(ref_im_i);
    end
  end

  always_comb begin
    // y * conj(x); power never exceeds 2^(2w-1) so it fits unsigned in 2w bits
    num_re  = NW'(p_rr_r) + NW'(p_ii_r);
    num_im  = NW'(p_ir_r) - NW'(p_ri_r);
    power   = PW'(p_xr_r) + PW'(p_xi_r);
    div_nxt = (SW+1)'(power >> (SW - 1));
    abs_re  = num_re[NW-1] ? (NW'(0) - num_re) : num_re;
    abs_im  = num_im[NW-1] ? (NW'(0) - num_im) : num_im;
    mag_re_nxt = abs_re[PW-1:0];
    mag_im_nxt = abs_im[PW-1:0];
    flags_nxt.too_small = (CW'(power) < CW'(min_power_r)) || (div_nxt == '0);
    flags_nxt.neg_re    = num_re[NW-1];
    flags_nxt.neg_im    = num_im[NW-1];
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      flags_r  <= flags_nxt;
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      div_r    <= div_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lspcd_back.sv
// back end: pipelined restoring divider, one quotient bit per stage after saturation
`timescale 1ns / 1ps
`default_nettype none

module lspcd_back #(
  parameter int SAMPLE_WIDTH = lspcd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid_i,
  output logic                         q_pop_o,
  input  wire lspcd_pkg::lspcd_flags_t q_flags_i,
  input  wire logic [2*SAMPLE_WIDTH-1:0] q_mag_re_i,
  input  wire logic [2*SAMPLE_WIDTH-1:0] q_mag_im_i,
  input  wire logic [SAMPLE_WIDTH:0]   q_div_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]      est_re_o,
  output logic [SAMPLE_WIDTH-1:0]      est_im_o,
  output logic                         too_small_o
);

  import lspcd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = 2 * SW;
  localparam int NW = 2 * SW + 1;
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};

  logic              en;
  logic [SW-1:0]     v_r;
  lspcd_flags_t      fl_r  [SW];
  logic [SW:0]       d_r   [SW];
  logic [PW-1:0]     rre_r [SW];
  logic [PW-1:0]     rim_r [SW];
  logic [SW-2:0]     qre_r [SW];
  logic [SW-2:0]     qim_r [SW];
  logic              sre_r [SW];
  logic              sim_r [SW];

  logic              ov_r;
  logic [SW-1:0]     est_re_r, est_im_r, est_re_nxt, est_im_nxt;
  logic              ts_r;

  function automatic logic [SW-1:0] fmt(input logic ts, input logic neg, input logic sat,
                                        input logic [SW-2:0] q);
    logic [SW-1:0] m;
    m = sat ? SAT_MAX : {1'b0, q};
    if (ts) begin
      return '0;
    end
    return neg ? (SW'(0) - m) : m;
  endfunction

  // one global advance; the queue in front absorbs the stall
  assign en          = !ov_r || out_ready_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = ov_r;
  assign est_re_o    = est_re_r;
  assign est_im_o    = est_im_r;
  assign too_small_o = ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[SW-2:0], q_valid_i};
      ov_r <= v_r[SW-1];
    end
  end

  // first stage: quotient at or above 2^(w-1) saturates
  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0]  <= q_flags_i;
      d_r[0]   <= q_div_i;
      rre_r[0] <= q_mag_re_i;
      rim_r[0] <= q_mag_im_i;
      qre_r[0] <= '0;
      qim_r[0] <= '0;
      sre_r[0] <= NW'(q_mag_re_i) >= (NW'(q_div_i) << (SW - 1));
      sim_r[0] <= NW'(q_mag_im_i) >= (NW'(q_div_i) << (SW - 1));
    end
  end

  for (genvar j = 1; j < SW; j++) begin : g_stage
    logic [PW-1:0] dk;
    logic          bre, bim;

    assign dk  = PW'(d_r[j-1]) << (SW - 1 - j);
    assign bre = rre_r[j-1] >= dk;
    assign bim = rim_r[j-1] >= dk;

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[j]  <= fl_r[j-1];
        d_r[j]   <= d_r[j-1];
        sre_r[j] <= sre_r[j-1];
        sim_r[j] <= sim_r[j-1];
        rre_r[j] <= bre ? (rre_r[j-1] - dk) : rre_r[j-1];
        rim_r[j] <= bim ? (rim_r[j-1] - dk) : rim_r[j-1];
        qre_r[j] <= {qre_r[j-1][SW-3:0], bre};
        qim_r[j] <= {qim_r[j-1][SW-3:0], bim};
      end
    end
  end

  always_comb begin
    est_re_nxt = fmt(fl_r[SW-1].too_small, fl_r[SW-1].neg_re, sre_r[SW-1], qre_r[SW-1]);
    est_im_nxt = fmt(fl_r[SW-1].too_small, fl_r[SW-1].neg_im, sim_r[SW-1], qim_r[SW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est_re_r <= est_re_nxt;
      est_im_r <= est_im_nxt;
      ts_r     <= fl_r[SW-1].too_small;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ls_pilot_complex_divide.sv
// top level of the least-squares pilot channel estimator (complex divide)
`timescale 1ns / 1ps
`default_nettype none

// Per pilot beat, returns H = Y / X in the sample format, with Y the received
// and X the reference sample. If the reference power is below min_power, or
// the power shifted down by SAMPLE_WIDTH-1 is zero, the estimate is zero and
// too_small (out_tuser) is set; otherwise each part is truncated toward zero
// and saturated to +/-(2^(SAMPLE_WIDTH-1)-1). One beat is accepted every clock
// while in_tready is high. A beat passes through two front stages
// (multipliers, then power and threshold), the four-entry queue,
// SAMPLE_WIDTH divider stages (a saturation check, then one quotient bit per
// stage) and the output register. Output stalls fill the queue before
// in_tready drops.

module ls_pilot_complex_divide #(
  parameter int SAMPLE_WIDTH = lspcd_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lspcd_pkg::CFG_WIDTH-1:0] cfg_wr_data,  // min_power
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // received_re, received_im, reference_re, reference_im, zero pad
  input  wire logic [IN_TDATA_W-1:0]           in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // estimate_re, estimate_im, zero pad
  output logic [OUT_TDATA_W-1:0]               out_tdata,
  // too_small
  output logic                                 out_tuser
);

  import lspcd_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  // flags, two 2w-bit magnitudes and the (w+1)-bit divisor
  localparam int Q_W = $bits(lspcd_flags_t) + 5 * SW + 1;

  logic                 push, full, q_valid, q_pop;
  lspcd_flags_t         f_flags, q_flags;
  logic [2*SW-1:0]      f_mag_re, f_mag_im, q_mag_re, q_mag_im;
  logic [SW:0]          f_div, q_div;
  logic [Q_W-1:0]       q_pop_data;
  logic [SW-1:0]        est_re, est_im;

  lspcd_front #(.SAMPLE_WIDTH(SW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .rx_re_i     (in_tdata[SW-1:0]),
    .rx_im_i     (in_tdata[2*SW-1:SW]),
    .ref_re_i    (in_tdata[3*SW-1:2*SW]),
    .ref_im_i    (in_tdata[4*SW-1:3*SW]),
    .push_o      (push),
    .full_i      (full),
    .flags_o     (f_flags),
    .mag_re_o    (f_mag_re),
    .mag_im_o    (f_mag_im),
    .div_o       (f_div)
  );

  lspcd_fifo #(.DATA_W(Q_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i ({f_flags, f_mag_re, f_mag_im, f_div}),
    .full_o      (full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .valid_o     (q_valid)
  );

  assign {q_flags, q_mag_re, q_mag_im, q_div} = q_pop_data;

  lspcd_back #(.SAMPLE_WIDTH(SW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_flags_i   (q_flags),
    .q_mag_re_i  (q_mag_re),
    .q_mag_im_i  (q_mag_im),
    .q_div_i     (q_div),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .est_re_o    (est_re),
    .est_im_o    (est_im),
    .too_small_o (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({est_im, est_re});

endmodule

`default_nettype wire

FILE: rtl/lspcd_chk.sv
// port-level checks for the pilot complex divide block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lspcd_chk #(
  parameter int SAMPLE_WIDTH = lspcd_pkg::SAMPLE_WIDTH_DEF,
  localparam int OUT_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  import lspcd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam logic [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // flagged beats carry a zero estimate
  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("too_small beat with nonzero estimate");

  // saturation is symmetric, the most negative code never appears
  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SW-1:0] != MOST_NEG && out_tdata[2*SW-1:SW] != MOST_NEG)
    else $error("estimate holds the most negative code");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind ls_pilot_complex_divide lspcd_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lspcd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: sim/lspcd_checker.sv
// checker for the pilot complex divide block: predicts each estimate and compares
`timescale 1ns / 1ps

module lspcd_checker
  import lspcd_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_WIDTH-1:0]       cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [((4*SW+7)/8)*8-1:0]  in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [((2*SW+7)/8)*8-1:0]  out_tdata,
  input  logic                       out_tuser,
  output int                         fail_count,
  output int                         outstanding,
  output int                         checked_count,
  output int                         flagged_count
);

  localparam longint SAT = (longint'(1) <<< (SW - 1)) - 1;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 too_small;
  } pilot_estimate_t;

  logic [CFG_WIDTH-1:0] min_power;
  pilot_estimate_t      estimate_q[$];

  function automatic logic signed [SW-1:0] clip_sample(input longint v);
    if (v > SAT) return SW'(SAT);
    if (v < -SAT) return SW'(-SAT);
    return SW'(v);
  endfunction

  // least-squares estimate y / x, truncated toward zero and saturated
  function automatic pilot_estimate_t divide_pilot(input logic signed [SW-1:0] y_re,
                                                   input logic signed [SW-1:0] y_im,
                                                   input logic signed [SW-1:0] x_re,
                                                   input logic signed [SW-1:0] x_im,
                                                   input logic [CFG_WIDTH-1:0] thresh);
    longint power, divisor, num_re, num_im;
    pilot_estimate_t e;
    power   = longint'(x_re) * longint'(x_re) + longint'(x_im) * longint'(x_im);
    divisor = power >>> (SW - 1);
    e = '0;
    if (power < longint'(thresh) || divisor == 0) begin
      e.too_small = 1'b1;
    end else begin
      num_re = longint'(y_re) * longint'(x_re) + longint'(y_im) * longint'(x_im);
      num_im = longint'(y_im) * longint'(x_re) - longint'(y_re) * longint'(x_im);
      e.re = clip_sample(num_re / divisor);
      e.im = clip_sample(num_im / divisor);
    end
    return e;
  endfunction

  always @(posedge clk) begin
    pilot_estimate_t want;
    pilot_estimate_t got;
    pilot_estimate_t pred;
    if (!rst_n) begin
      min_power = MIN_POWER_RESET;
      estimate_q.delete();
      outstanding = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.re        = out_tdata[SW-1:0];
        got.im        = out_tdata[2*SW-1:SW];
        got.too_small = out_tuser;
        if (estimate_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat: expected none, actual re=%0d im=%0d too_small=%0b",
                   $time, got.re, got.im, got.too_small);
        end else begin
          want = estimate_q.pop_front();
          checked_count++;
          if (want.too_small) flagged_count++;
          if (got.re !== want.re || got.im !== want.im || got.too_small !== want.too_small)
          begin
            fail_count++;
            $display("%0t: mismatch: expected re=%0d im=%0d ts=%0b, actual re=%0d im=%0d ts=%0b",
                     $time, want.re, want.im, want.too_small,
                     got.re, got.im, got.too_small);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pred = divide_pilot(in_tdata[SW-1:0], in_tdata[2*SW-1:SW],
                            in_tdata[3*SW-1:2*SW], in_tdata[4*SW-1:3*SW],
                            min_power);
        estimate_q = {estimate_q, pred};
      end
      if (cfg_wr_en) min_power = cfg_wr_data;
      outstanding = estimate_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// testbench top for the pilot complex divide block: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_top;
  import lspcd_pkg::*;

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int LATENCY   = SW + 4;
  localparam int LONG_HOLD = 80;
  localparam logic signed [SW-1:0] Q_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] Q_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CFG_WIDTH-1:0] THRESH_TOP = 32'h8000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_WIDTH-1:0]  cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [4*SW-1:0]       in_tdata;   // received_re, received_im, reference_re, reference_im
  logic                  out_tvalid;
  logic                  out_tready;
  logic [2*SW-1:0]       out_tdata;  // estimate_re, estimate_im
  logic                  out_tuser;  // too_small

  int fail_count, outstanding, checked_count, flagged_count;
  int tx_gap_pct, rx_stall_pct;
  int pilots_sent, settings_used;
  int power_root;
  bit hold_request;

  ls_pilot_complex_divide #(.SAMPLE_WIDTH(SW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lspcd_checker #(.SW(SW)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked_count(checked_count),
    .flagged_count(flagged_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          out_tready <= 1'b0;
          held++;
          @(negedge clk);
        end
      end
      out_tready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_pilot(input logic signed [SW-1:0] y_re, input logic signed [SW-1:0] y_im,
                            input logic signed [SW-1:0] x_re, input logic signed [SW-1:0] x_im);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {x_im, x_re, y_im, y_re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pilots_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
  endtask

  task automatic set_min_power(input logic [CFG_WIDTH-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
    power_root = int'($sqrt(real'(value)));
    if (power_root > int'(Q_MAX)) power_root = int'(Q_MAX);
  endtask

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return SW'(1);
      default: return '1;
    endcase
  endfunction

  // mix of full-range, tiny, near-threshold and extreme references
  function automatic logic signed [SW-1:0] draw_reference();
    logic signed [SW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = SW'($urandom);
      3:       v = SW'($urandom_range(0, 400));
      4:       v = SW'(power_root + $urandom_range(0, 8) - 4);
      default: v = pick_extreme();
    endcase
    if (v != Q_MIN && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic signed [SW-1:0] draw_received();
    if ($urandom_range(0, 4) == 0) return pick_extreme();
    return SW'($urandom);
  endfunction

  task automatic run_random(input int count);
    repeat (count)
      send_pilot(draw_received(), draw_received(), draw_reference(), draw_reference());
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    hold_request = 1'b0;
    tx_gap_pct   = 8;
    rx_stall_pct = 65;
    power_root   = 10;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset threshold: extremes, saturation, low power and zero divisor
    send_pilot('0, '0, Q_MAX, '0);
    send_pilot(Q_MAX, Q_MIN, Q_MAX, '0);
    send_pilot(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_pilot(Q_MAX, Q_MAX, Q_MIN, Q_MIN);
    send_pilot(Q_MIN, Q_MAX, Q_MIN, '0);
    send_pilot(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_pilot(Q_MIN, Q_MIN, '0, Q_MIN);
    send_pilot(SW'(1234), SW'(-4321), '0, Q_MIN);
    send_pilot(Q_MAX, Q_MAX, '0, '0);
    send_pilot(SW'(100), SW'(-100), SW'(5), SW'(5));
    send_pilot(SW'(100), SW'(-100), SW'(7), SW'(7));
    send_pilot(Q_MAX, Q_MIN, SW'(10), '0);
    send_pilot(Q_MAX, Q_MIN, SW'(181), '0);
    send_pilot(Q_MAX, Q_MIN, SW'(182), '0);
    send_pilot(Q_MIN, Q_MAX, SW'(-182), '0);
    send_pilot(SW'(-1), SW'(1), SW'(301), '0);
    send_pilot(SW'(1), SW'(-1), SW'(-301), '0);
    send_pilot(SW'(-3), SW'(7), SW'(200), SW'(150));
    send_pilot('1, '1, '1, '1);
    send_pilot(Q_MIN, Q_MIN, '1, '0);
    send_pilot(SW'(1), '0, Q_MAX, Q_MAX);
    send_pilot(SW'(-5), SW'(3), Q_MIN, Q_MAX);
    send_pilot(16'sh5555, 16'shAAAA, 16'sh2AAA, 16'shD555);

    set_min_power('0);
    run_random(200);
    set_min_power(32'd32768);
    run_random(200);
    // only the full-scale corner reference clears this threshold
    set_min_power(THRESH_TOP);
    send_pilot(Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    send_pilot(SW'(-1000), SW'(2000), Q_MIN, Q_MIN);
    send_pilot(Q_MAX, Q_MAX, Q_MIN, -Q_MAX);
    run_random(150);

    tx_gap_pct   = 65;
    rx_stall_pct = 8;
    set_min_power(32'd1 << 24);
    run_random(250);
    set_min_power(32'd32767);
    run_random(200);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_min_power(MIN_POWER_RESET);
    hold_request = 1'b1;
    run_random(300);
    set_min_power(32'd1 << 28);
    run_random(300);

    drain();
    $display("run covered %0d pilots over %0d threshold settings and three idling mixes",
             pilots_sent, settings_used + 1);
    $display("%0d estimates checked, %0d of them forced to zero for low reference power",
             checked_count, flagged_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lspcd_pkg.sv
rtl/lspcd_fifo.sv
rtl/lspcd_front.sv
rtl/lspcd_back.sv
rtl/ls_pilot_complex_divide.sv
rtl/lspcd_chk.sv
sim/lspcd_checker.sv
sim/tb_top.sv
